// File: src/pefq_pkg.sv
package pefq_pkg;

  // Sizing
  localparam int QUEUE_DEPTH   = 16;
  localparam int PAYLOAD_BITS  = 32;
  localparam int PRIORITY_BITS = 8;
  localparam int IDX_W         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_ZERO = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_PRIO = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TAKE_MAX  = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_SCAN  = IDX_W'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0]  payload;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  // Running best candidate handed along the chain
  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         idx;
    logic [PRIORITY_BITS-1:0] prio;
    logic [PAYLOAD_BITS-1:0]  payload;
  } best_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_SHIFT
  } cell_op_t;

  // Control broadcast to every cell
  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] occ;
    logic [IDX_W-1:0] pos;
    entry_t           push_entry;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

endpackage

// File: src/pefq_cell.sv
module pefq_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [pefq_pkg::IDX_W-1:0] idx,
  input  pefq_pkg::cell_ctl_t        ctl,
  input  pefq_pkg::entry_t           next_entry,
  input  pefq_pkg::best_t            best_in,
  output pefq_pkg::entry_t           entry,
  output pefq_pkg::best_t            best_c,
  output pefq_pkg::best_t            best_q
);
  import pefq_pkg::*;

  logic occupied;

  assign occupied = {1'b0, idx} < ctl.occ;

  // Hold, load a new tail entry, or take the neighbor's entry to close a gap
  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_PUSH: begin
        if ({1'b0, idx} == ctl.occ) begin
          entry <= ctl.push_entry;
        end
      end
      CELL_SHIFT: begin
        if (idx >= ctl.pos) begin
          entry <= next_entry;
        end
      end
      default: begin
      end
    endcase
  end

  // Replace the candidate only on a strictly higher priority: older wins ties
  always_comb begin
    best_c = best_in;
    if (occupied && (!best_in.valid || entry.prio > best_in.prio)) begin
      best_c.valid   = 1'b1;
      best_c.idx     = idx;
      best_c.prio    = entry.prio;
      best_c.payload = entry.payload;
    end
  end

  // Advance the candidate one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      best_q.valid <= 1'b0;
    end else begin
      best_q <= best_c;
    end
  end

endmodule

// File: src/priority_extract_fifo_queue_core.sv
// Ordered queue of up to QUEUE_DEPTH entries (payload word plus priority)
// held in a chain of cells, oldest entry in cell 0.
// Request channel: a request is taken at a rising edge with start high and
// busy low; command, payload and priority_req are sampled at that edge.
// Commands: push at priority zero, push with priority_req, pop oldest,
// peek oldest, take highest priority (oldest wins a tie).
// Result channel: done is high for exactly one cycle with status, data_out
// and entry_count valid; the receiver cannot stall, so it must take the
// result in that cycle.
// Flow: push, pop, peek, unused codes and any request on an empty queue
// give their result in the cycle after acceptance, and a new request can be
// taken every cycle while busy is low. Take on a non-empty queue runs a scan
// in which the best candidate moves one cell per clock down the chain: busy
// stays high until it reaches the last cell, where the result is registered.
// Removal closes the gap by moving every entry past the removed one down a cell.
// Reset (synchronous, rst high) empties the queue and clears done and busy;
// entry contents are not cleared and are never read before being written.
module priority_extract_fifo_queue_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [pefq_pkg::CMD_W-1:0]           command,
  input  logic [pefq_pkg::PAYLOAD_BITS-1:0]    payload,
  input  logic [pefq_pkg::PRIORITY_BITS-1:0]   priority_req,
  output logic                                 done,
  output logic [pefq_pkg::STATUS_W-1:0]        status,
  output logic [pefq_pkg::PAYLOAD_BITS-1:0]    data_out,
  output logic [pefq_pkg::CNT_W-1:0]           entry_count
);
  import pefq_pkg::*;

  state_t                   state, state_next;
  logic [IDX_W-1:0]         cnt, cnt_next;
  logic [CNT_W-1:0]         occ, occ_next;
  logic                     done_next;
  logic [STATUS_W-1:0]      status_next;
  logic [PAYLOAD_BITS-1:0]  data_out_next;
  logic                     accept;
  logic                     empty;
  logic                     scan_end;
  cell_ctl_t                ctl;

  entry_t cell_entry [QUEUE_DEPTH];
  entry_t cell_next  [QUEUE_DEPTH];
  best_t  cell_bin   [QUEUE_DEPTH];
  best_t  cell_bc    [QUEUE_DEPTH];
  best_t  cell_bq    [QUEUE_DEPTH];

  assign busy     = (state == S_SCAN);
  assign accept   = start && !busy;
  assign empty    = (occ == '0);
  assign scan_end = (state == S_SCAN) && (cnt == LAST_SCAN);

  // Build the chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_bin[i] = '0;
    end else begin : g_body
      assign cell_bin[i] = cell_bq[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign cell_next[i] = '0;
    end else begin : g_link
      assign cell_next[i] = cell_entry[i+1];
    end
    pefq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .idx        (IDX_W'(i)),
      .ctl        (ctl),
      .next_entry (cell_next[i]),
      .best_in    (cell_bin[i]),
      .entry      (cell_entry[i]),
      .best_c     (cell_bc[i]),
      .best_q     (cell_bq[i])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && command == CMD_TAKE_MAX && !empty) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: cell control and the result of the request
  always_comb begin
    ctl.op         = CELL_HOLD;
    ctl.occ        = occ;
    ctl.pos        = '0;
    ctl.push_entry.payload = payload;
    ctl.push_entry.prio    = (command == CMD_PUSH_PRIO) ? priority_req : '0;
    occ_next       = occ;
    cnt_next       = '0;
    done_next      = 1'b0;
    status_next    = STAT_DONE;
    data_out_next  = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          case (command)
            CMD_PUSH_ZERO, CMD_PUSH_PRIO: begin
              if (occ == FULL_COUNT) begin
                status_next = STAT_FULL;
              end else begin
                ctl.op   = CELL_PUSH;
                occ_next = occ + 1'b1;
              end
            end
            CMD_POP: begin
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                ctl.op   = CELL_SHIFT;
                occ_next = occ - 1'b1;
              end
            end
            CMD_PEEK: begin
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                data_out_next = cell_entry[0].payload;
              end
            end
            CMD_TAKE_MAX: begin
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                done_next = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        cnt_next = cnt + 1'b1;
        if (scan_end) begin
          ctl.op        = CELL_SHIFT;
          ctl.pos       = cell_bc[QUEUE_DEPTH-1].idx;
          data_out_next = cell_bc[QUEUE_DEPTH-1].payload;
          occ_next      = occ - 1'b1;
          done_next     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      occ   <= occ_next;
      done  <= done_next;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    status      <= status_next;
    data_out    <= data_out_next;
    entry_count <= occ_next;
  end

  a_no_result_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !done)
    else $error("result strobe during scan");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= FULL_COUNT)
    else $error("occupancy above depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (occ != '0))
    else $error("scan on empty queue");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_FULL) |-> (entry_count == FULL_COUNT))
    else $error("full status with queue not full");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_POP && empty) |=> (done && status == STAT_EMPTY))
    else $error("pop on empty queue not reported");

endmodule
